// File: rtl/dba_pkg.sv
// shared types and constants of the decimating band-pass audio block
// no dependencies; the bench and every other rtl file but the checker refer to it by scoped names
package dba_pkg;

	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 64;
	localparam int FF_W     = 60;
	localparam int FB_W     = 40;
	localparam int SAMPLE_W = 16;
	localparam int LEN_W    = 13;
	localparam int IDX_W    = 10;
	localparam int POS_W    = 13;
	localparam int REM_W    = 8;

	localparam logic [1:0] REG_HP_FF = 2'd0;
	localparam logic [1:0] REG_HP_FB = 2'd1;
	localparam logic [1:0] REG_LP_FF = 2'd2;
	localparam logic [1:0] REG_LP_FB = 2'd3;

	localparam logic [POS_W-1:0] POS_MAX   = 13'd8191;
	localparam logic [LEN_W-1:0] MAX_BLOCK = 13'd4096;

	// output limit: (320*len + 441) / 882 as a multiply by the rounded-up reciprocal of 882
	localparam int LIM_NW    = 22;
	localparam int LIM_QW    = 12;
	localparam int LIM_RW    = 22;
	localparam int LIM_SHIFT = 31;
	localparam logic [LIM_RW-1:0] LIM_RECIP = 22'd2434789;
	localparam logic [LIM_NW-1:0] LIM_BIAS  = 22'd441;

	// base index tracking: base(j) = floor(441*j/160)
	localparam logic [POS_W-1:0] BASE_STEP = 13'd2;
	localparam logic [REM_W:0]   REM_STEP  = 9'd121;
	localparam logic [REM_W:0]   REM_MOD   = 9'd160;

	typedef logic [3:0] step_t;

	localparam step_t STEP_HP_B0    = 4'd0;
	localparam step_t STEP_HP_B1    = 4'd1;
	localparam step_t STEP_HP_B2    = 4'd2;
	localparam step_t STEP_HP_A1    = 4'd3;
	localparam step_t STEP_HP_A2    = 4'd4;
	localparam step_t STEP_LP_B0    = 4'd5;
	localparam step_t STEP_LP_B1    = 4'd6;
	localparam step_t STEP_LP_B2    = 4'd7;
	localparam step_t STEP_LP_A1    = 4'd8;
	localparam step_t STEP_LP_A2    = 4'd9;
	localparam step_t STEP_LIM_LAST = 4'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LIMIT,
		ST_AVG,
		ST_QUOT,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND,
		ST_SCALE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic  accept;
		logic  lim_step;
		logic  lim_last;
		logic  avg;
		logic  quot;
		logic  mac;
		step_t step;
		logic  round;
		logic  lp_stage;
		logic  scale;
		logic  emit;
	} cmd_t;

	typedef struct packed {
		logic start;
		logic fire;
		logic out_free;
	} status_t;

endpackage

// File: rtl/dba_regs.sv
// apb coefficient register file of the decimating band-pass block
// depends on dba_pkg for register indexes and widths
module dba_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dba_pkg::ADDR_W-1:0]   paddr,
	input  logic [dba_pkg::DATA_W-1:0]   pwdata,
	output logic [dba_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output logic [dba_pkg::FF_W-1:0]     hp_ff,
	output logic [dba_pkg::FB_W-1:0]     hp_fb,
	output logic [dba_pkg::FF_W-1:0]     lp_ff,
	output logic [dba_pkg::FB_W-1:0]     lp_fb
);

	logic [dba_pkg::FF_W-1:0] hp_ff_q;
	logic [dba_pkg::FB_W-1:0] hp_fb_q;
	logic [dba_pkg::FF_W-1:0] lp_ff_q;
	logic [dba_pkg::FB_W-1:0] lp_fb_q;
	logic [1:0]               sel;
	logic                     wr;

	assign pready = 1'b1;
	assign sel    = paddr[dba_pkg::ADDR_W-1:dba_pkg::ADDR_W-2];
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_ff_q <= '0;
			hp_fb_q <= '0;
			lp_ff_q <= '0;
			lp_fb_q <= '0;
		end else if (wr) begin
			unique case (sel)
				dba_pkg::REG_HP_FF: hp_ff_q <= pwdata[dba_pkg::FF_W-1:0];
				dba_pkg::REG_HP_FB: hp_fb_q <= pwdata[dba_pkg::FB_W-1:0];
				dba_pkg::REG_LP_FF: lp_ff_q <= pwdata[dba_pkg::FF_W-1:0];
				dba_pkg::REG_LP_FB: lp_fb_q <= pwdata[dba_pkg::FB_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			dba_pkg::REG_HP_FF: prdata = dba_pkg::DATA_W'(hp_ff_q);
			dba_pkg::REG_HP_FB: prdata = dba_pkg::DATA_W'(hp_fb_q);
			dba_pkg::REG_LP_FF: prdata = dba_pkg::DATA_W'(lp_ff_q);
			dba_pkg::REG_LP_FB: prdata = dba_pkg::DATA_W'(lp_fb_q);
			default:            prdata = '0;
		endcase
	end

	assign hp_ff = hp_ff_q;
	assign hp_fb = hp_fb_q;
	assign lp_ff = lp_ff_q;
	assign lp_fb = lp_fb_q;

endmodule

// File: rtl/dba_ctrl.sv
// sequencing state machine of the decimating band-pass block
// depends on dba_pkg for state, command and status types
module dba_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  dba_pkg::status_t status,
	output dba_pkg::cmd_t    cmd
);

	dba_pkg::state_t state_q, state_d;
	dba_pkg::step_t  cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dba_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		cmd.step = cnt_q;
		in_ready = 1'b0;
		unique case (state_q)
			dba_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cnt_d    = '0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (status.start) begin
						state_d = dba_pkg::ST_LIMIT;
					end else if (status.fire) begin
						state_d = dba_pkg::ST_AVG;
					end
				end
			end
			dba_pkg::ST_LIMIT: begin
				cmd.lim_step = 1'b1;
				cnt_d        = cnt_q + 4'd1;
				if (cnt_q == dba_pkg::STEP_LIM_LAST) begin
					cmd.lim_last = 1'b1;
					cnt_d        = '0;
					state_d      = dba_pkg::ST_IDLE;
				end
			end
			dba_pkg::ST_AVG: begin
				cmd.avg = 1'b1;
				state_d = dba_pkg::ST_QUOT;
			end
			dba_pkg::ST_QUOT: begin
				cmd.quot = 1'b1;
				state_d  = dba_pkg::ST_MAC;
			end
			dba_pkg::ST_MAC: begin
				cmd.mac = 1'b1;
				cnt_d   = cnt_q + 4'd1;
				if (cnt_q == dba_pkg::STEP_HP_A2 || cnt_q == dba_pkg::STEP_LP_A2) begin
					state_d = dba_pkg::ST_DRAIN;
				end
			end
			dba_pkg::ST_DRAIN: begin
				state_d = dba_pkg::ST_ROUND;
			end
			dba_pkg::ST_ROUND: begin
				cmd.round    = 1'b1;
				cmd.lp_stage = (cnt_q != dba_pkg::STEP_LP_B0);
				if (cnt_q != dba_pkg::STEP_LP_B0) begin
					state_d = dba_pkg::ST_SCALE;
				end else begin
					state_d = dba_pkg::ST_MAC;
				end
			end
			dba_pkg::ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = dba_pkg::ST_EMIT;
			end
			dba_pkg::ST_EMIT: begin
				cmd.emit = status.out_free;
				if (status.out_free) begin
					state_d = dba_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dba_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/dba_dp.sv
// datapath of the decimating band-pass block: block bookkeeping, output limit multiply,
// two- or three-tap average, shared multiply-accumulate for both biquads, output register
// depends on dba_pkg for command and status types and fixed constants
module dba_dp #(
	parameter int OUT_LIMIT   = 1024,
	parameter int COEF_WIDTH  = 20,
	parameter int STATE_WIDTH = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dba_pkg::cmd_t                       cmd,
	output dba_pkg::status_t                    status,
	input  logic signed [dba_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                block_start,
	input  logic [dba_pkg::LEN_W-1:0]           block_length,
	input  logic [dba_pkg::FF_W-1:0]            hp_ff,
	input  logic [dba_pkg::FB_W-1:0]            hp_fb,
	input  logic [dba_pkg::FF_W-1:0]            lp_ff,
	input  logic [dba_pkg::FB_W-1:0]            lp_fb,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [dba_pkg::SAMPLE_W-1:0] sample_out,
	output logic [dba_pkg::IDX_W-1:0]           out_index
);

	localparam int CW  = COEF_WIDTH;
	localparam int SW  = STATE_WIDTH;
	localparam int CF  = CW - 3;
	localparam int SF  = SW - 4;
	localparam int OPW = $clog2(OUT_LIMIT + 1);
	localparam int TW  = SF + 2;
	localparam int MW  = CW + SW;
	localparam int AW  = CW + SW + 3;
	localparam int XW  = SW + 16;
	localparam int QW  = dba_pkg::LIM_QW;
	localparam int NW  = dba_pkg::LIM_NW;
	localparam int LPW = dba_pkg::LIM_NW + dba_pkg::LIM_RW;
	localparam int PW  = dba_pkg::POS_W;

	localparam logic [TW-1:0]         RECIP   = TW'((64'd1 << TW) / 64'd3);
	localparam logic [OPW-1:0]        OUT_MAX = OPW'(OUT_LIMIT);
	localparam logic signed [SW-1:0]  Y_HI    = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0]  Y_LO    = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [AW-1:0]  RND     = AW'(64'd1 << (CF - 1));
	localparam logic signed [XW-1:0]  SC_HI   = XW'(32767);
	localparam logic signed [XW-1:0]  SC_LO   = XW'(-32767);
	localparam logic signed [XW-1:0]  SC_BIAS = XW'((64'd1 << SF) - 64'd1);
	localparam logic signed [XW-1:0]  SC_ZERO = XW'(0);

	// block bookkeeping
	logic signed [dba_pkg::SAMPLE_W-1:0] r0_q, r1_q;
	logic [PW-1:0]                       in_pos_q, base_q;
	logic [dba_pkg::REM_W-1:0]           rem_q;
	logic [OPW-1:0]                      out_pos_q, lim_q, idx_q;

	// output limit
	logic [NW-1:0]  n_q;
	logic [LPW-1:0] lim_prod_s1;

	// average
	logic signed [17:0]  sum_q;
	logic                cnt3_q, neg_q;
	logic [TW-1:0]       t_q;
	logic [2*TW-1:0]     prod_s1;
	logic signed [SW-1:0] avg_q;

	// mac and filter state
	logic signed [MW-1:0] mul_s1;
	logic                 mneg_s1, mv_s1;
	logic signed [AW-1:0] acc_q;
	logic signed [SW-1:0] hp_q;
	logic signed [SW-1:0] hx0_q, hx1_q, hy0_q, hy1_q, ly0_q, ly1_q;
	logic signed [XW-1:0] p_q;

	// output register
	logic                                ov_q;
	logic signed [dba_pkg::SAMPLE_W-1:0] so_q;
	logic [dba_pkg::IDX_W-1:0]           oi_q;

	// combinational
	logic [PW-1:0]            base_inc, base_next, in_pos_inc;
	logic [dba_pkg::REM_W:0]  rem_sum;
	logic                     rem_wrap, cnt3_d;
	logic [dba_pkg::REM_W-1:0] rem_next;
	logic signed [17:0]       sum_d;
	logic [dba_pkg::LEN_W-1:0] len_c;
	logic [NW-1:0]            num;
	logic [QW-1:0]            q_lim;
	logic [OPW-1:0]           lim_next;
	logic [16:0]              abs_sum;
	logic [17+SF-1:0]         wide;
	logic [TW-1:0]            t_d, q0, qc, mag;
	logic [TW+1:0]            q3, rr;
	logic signed [SW-1:0]     mag_s, avg_d;
	logic [3*CW-1:0]          ffh, ffl;
	logic [2*CW-1:0]          fbh, fbl;
	logic signed [CW-1:0]     coef;
	logic signed [SW-1:0]     opnd;
	logic                     fbk;
	logic signed [AW-1:0]     rsum, rsh;
	logic signed [SW-1:0]     y;
	logic signed [XW-1:0]     lpx, p_d, sc_w;
	logic signed [dba_pkg::SAMPLE_W-1:0] sc;

	assign base_inc = base_q + 13'd1;

	always_comb begin
		status.start    = block_start;
		status.fire     = !block_start && (out_pos_q < lim_q) && (base_inc == in_pos_q);
		status.out_free = !ov_q || out_ready;
	end

	assign cnt3_d     = (base_q != '0);
	assign sum_d      = 18'(sample_in) + 18'(r0_q) + (cnt3_d ? 18'(r1_q) : 18'sd0);
	assign rem_sum    = (dba_pkg::REM_W+1)'(rem_q) + dba_pkg::REM_STEP;
	assign rem_wrap   = (rem_sum >= dba_pkg::REM_MOD);
	assign rem_next   = rem_wrap ? dba_pkg::REM_W'(rem_sum - dba_pkg::REM_MOD)
	                             : dba_pkg::REM_W'(rem_sum);
	assign base_next  = base_q + dba_pkg::BASE_STEP + PW'(rem_wrap);
	assign in_pos_inc = (in_pos_q < dba_pkg::POS_MAX) ? in_pos_q + 13'd1 : in_pos_q;

	assign len_c = (block_length > dba_pkg::MAX_BLOCK) ? dba_pkg::MAX_BLOCK : block_length;
	assign num   = (NW'(len_c) << 8) + (NW'(len_c) << 6) + dba_pkg::LIM_BIAS;

	assign q_lim    = lim_prod_s1[dba_pkg::LIM_SHIFT +: QW];
	assign lim_next = ({1'b0, q_lim} > (QW+1)'(OUT_LIMIT)) ? OUT_MAX : OPW'(q_lim);

	// trunc(|sum| * 2^SF / 32768), divided by 2 or 3 afterwards
	assign abs_sum = sum_q[17] ? 17'(-sum_q) : 17'(sum_q);
	assign wide    = {abs_sum, {SF{1'b0}}};
	assign t_d     = TW'(wide >> 15);

	assign q0    = prod_s1[2*TW-1 -: TW];
	assign q3    = (TW+2)'(q0) + ((TW+2)'(q0) << 1);
	assign rr    = (TW+2)'(t_q) - q3;
	assign qc    = q0 + TW'(rr >= (TW+2)'(3));
	assign mag   = cnt3_q ? qc : (t_q >> 1);
	assign mag_s = SW'(mag);
	assign avg_d = neg_q ? -mag_s : mag_s;

	assign ffh = (3*CW)'(hp_ff);
	assign ffl = (3*CW)'(lp_ff);
	assign fbh = (2*CW)'(hp_fb);
	assign fbl = (2*CW)'(lp_fb);

	always_comb begin
		coef = '0;
		opnd = '0;
		fbk  = 1'b0;
		case (cmd.step)
			dba_pkg::STEP_HP_B0: begin coef = ffh[0*CW +: CW]; opnd = avg_q; end
			dba_pkg::STEP_HP_B1: begin coef = ffh[1*CW +: CW]; opnd = hx0_q; end
			dba_pkg::STEP_HP_B2: begin coef = ffh[2*CW +: CW]; opnd = hx1_q; end
			dba_pkg::STEP_HP_A1: begin coef = fbh[0*CW +: CW]; opnd = hy0_q; fbk = 1'b1; end
			dba_pkg::STEP_HP_A2: begin coef = fbh[1*CW +: CW]; opnd = hy1_q; fbk = 1'b1; end
			dba_pkg::STEP_LP_B0: begin coef = ffl[0*CW +: CW]; opnd = hp_q;  end
			dba_pkg::STEP_LP_B1: begin coef = ffl[1*CW +: CW]; opnd = hy0_q; end
			dba_pkg::STEP_LP_B2: begin coef = ffl[2*CW +: CW]; opnd = hy1_q; end
			dba_pkg::STEP_LP_A1: begin coef = fbl[0*CW +: CW]; opnd = ly0_q; fbk = 1'b1; end
			dba_pkg::STEP_LP_A2: begin coef = fbl[1*CW +: CW]; opnd = ly1_q; fbk = 1'b1; end
			default: ;
		endcase
	end

	// round half up, floor shift, saturate to state range
	assign rsum = acc_q + RND;
	assign rsh  = rsum >>> CF;
	assign y    = (rsh > AW'(Y_HI)) ? Y_HI : (rsh < AW'(Y_LO)) ? Y_LO : SW'(rsh);

	assign lpx  = XW'(ly0_q);
	assign p_d  = (lpx <<< 15) - lpx;
	assign sc_w = (p_q + (p_q[XW-1] ? SC_BIAS : SC_ZERO)) >>> SF;
	assign sc   = (sc_w > SC_HI) ? 16'sd32767 : (sc_w < SC_LO) ? -16'sd32767 : 16'(sc_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r0_q      <= '0;
			r1_q      <= '0;
			in_pos_q  <= '0;
			base_q    <= '0;
			rem_q     <= '0;
			out_pos_q <= '0;
			lim_q     <= '0;
			mv_s1     <= 1'b0;
			hx0_q     <= '0;
			hx1_q     <= '0;
			hy0_q     <= '0;
			hy1_q     <= '0;
			ly0_q     <= '0;
			ly1_q     <= '0;
			ov_q      <= 1'b0;
		end else begin
			mv_s1 <= cmd.mac;
			if (cmd.accept) begin
				r0_q <= sample_in;
				r1_q <= r0_q;
				if (block_start) begin
					in_pos_q  <= 13'd1;
					out_pos_q <= '0;
					base_q    <= '0;
					rem_q     <= '0;
				end else begin
					in_pos_q <= in_pos_inc;
					if (status.fire) begin
						out_pos_q <= out_pos_q + OPW'(1);
						base_q    <= base_next;
						rem_q     <= rem_next;
					end
				end
			end
			if (cmd.lim_last) begin
				lim_q <= lim_next;
			end
			if (cmd.round && cmd.lp_stage) begin
				hx1_q <= hx0_q;
				hx0_q <= avg_q;
				hy1_q <= hy0_q;
				hy0_q <= hp_q;
				ly1_q <= ly0_q;
				ly0_q <= y;
			end
			if (cmd.emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			n_q    <= num;
			idx_q  <= out_pos_q;
			sum_q  <= sum_d;
			cnt3_q <= cnt3_d;
		end
		if (cmd.lim_step) begin
			lim_prod_s1 <= LPW'(n_q) * LPW'(dba_pkg::LIM_RECIP);
		end
		if (cmd.avg) begin
			t_q     <= t_d;
			prod_s1 <= (2*TW)'(t_d) * (2*TW)'(RECIP);
			neg_q   <= sum_q[17];
		end
		if (cmd.quot) begin
			avg_q <= avg_d;
		end
		mul_s1  <= MW'(coef) * MW'(opnd);
		mneg_s1 <= fbk;
		if (cmd.quot || cmd.round) begin
			acc_q <= '0;
		end else if (mv_s1) begin
			acc_q <= mneg_s1 ? acc_q - AW'(mul_s1) : acc_q + AW'(mul_s1);
		end
		if (cmd.round && !cmd.lp_stage) begin
			hp_q <= y;
		end
		if (cmd.scale) begin
			p_q <= p_d;
		end
		if (cmd.emit) begin
			so_q <= sc;
			oi_q <= dba_pkg::IDX_W'(idx_q);
		end
	end

	assign out_valid  = ov_q;
	assign sample_out = so_q;
	assign out_index  = oi_q;

endmodule

// File: rtl/decimate_and_bandpass_audio.sv
// top level of the 44.1 kHz to 16 kHz decimator with high-pass and low-pass biquads
// a beat with a result runs avg, quot, then mac, drain, round per biquad, then scale and emit;
// s_axis_tready rises in the cycle its result shows on m_axis, so the next beat waits for it
// a beat with no result leaves the block idle; a start beat runs the two-step limit multiply
// ten filter products share one multiplier; a result waits in emit while m_axis stalls
// reset is asynchronous: coefficients, histories and counters clear, no output until a block start
module decimate_and_bandpass_audio #(
	parameter int OUT_LIMIT   = 1024,
	parameter int COEF_WIDTH  = 20,
	parameter int STATE_WIDTH = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dba_pkg::ADDR_W-1:0] paddr,
	input  logic [dba_pkg::DATA_W-1:0] pwdata,
	output logic [dba_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [31:0]                s_axis_tdata,  // sample_in[15:0], block_length[28:16]
	input  logic [0:0]                 s_axis_tuser,  // block_start
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [31:0]                m_axis_tdata   // sample_out[15:0], out_index[25:16]
);

	logic [dba_pkg::FF_W-1:0]            hp_ff, lp_ff;
	logic [dba_pkg::FB_W-1:0]            hp_fb, lp_fb;
	dba_pkg::cmd_t                       cmd;
	dba_pkg::status_t                    status;
	logic signed [dba_pkg::SAMPLE_W-1:0] sample_out;
	logic [dba_pkg::IDX_W-1:0]           out_index;

	dba_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.hp_ff   (hp_ff),
		.hp_fb   (hp_fb),
		.lp_ff   (lp_ff),
		.lp_fb   (lp_fb)
	);

	dba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	dba_dp #(
		.OUT_LIMIT   (OUT_LIMIT),
		.COEF_WIDTH  (COEF_WIDTH),
		.STATE_WIDTH (STATE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sample_in    (s_axis_tdata[15:0]),
		.block_start  (s_axis_tuser[0]),
		.block_length (s_axis_tdata[28:16]),
		.hp_ff        (hp_ff),
		.hp_fb        (hp_fb),
		.lp_ff        (lp_ff),
		.lp_fb        (lp_fb),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.sample_out   (sample_out),
		.out_index    (out_index)
	);

	assign m_axis_tdata = {6'b0, out_index, sample_out};

endmodule

// File: rtl/dba_checker.sv
// port-level checks of the decimating band-pass block, bound to the top level
// depends on no package; port widths are written out directly
module dba_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic [0:0]                 s_axis_tuser,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [31:0]                m_axis_tdata
);

	// result beat held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped before it was taken");

	// stalled result does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("stalled result beat changed");

	// block start runs the limit multiply before the next beat
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> !s_axis_tready)
		else $error("beat accepted while the output limit is still being computed");

	// saturation never yields the most negative code
	a_out_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:0] != 16'h8000)
		else $error("result sample outside the saturation range");

endmodule

bind decimate_and_bandpass_audio dba_checker u_dba_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: bench/tb_decimate_and_bandpass_audio.sv
`timescale 1ns / 1ps
// self-checking bench for decimate_and_bandpass_audio: directed and random sample blocks
// checked beat by beat against a bit-exact decimator and biquad predictor
// depends on dba_pkg and the block's rtl only
module tb_decimate_and_bandpass_audio;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE_WAIT  = 40;
	localparam int COEF_W       = 20;
	localparam int COEF_FRAC    = COEF_W - 3;
	localparam int SIG_FRAC     = 20;
	localparam longint STATE_HI = (64'sd1 <<< 23) - 1;
	localparam longint STATE_LO = -(64'sd1 <<< 23);
	localparam int OUT_CAP      = 1024;
	localparam int BLOCK_CAP    = 4096;
	localparam int POS_CAP      = 8191;

	typedef struct packed {
		logic [15:0] sample;
		logic        start;
		logic [12:0] len;
	} audio_beat_t;

	typedef struct packed {
		logic [15:0] sample;
		logic [9:0]  index;
	} audio_out_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [dba_pkg::ADDR_W-1:0] paddr = '0;
	logic [dba_pkg::DATA_W-1:0] pwdata = '0;
	logic [dba_pkg::DATA_W-1:0] prdata;
	logic                       pready;
	logic                       s_axis_tvalid = 1'b0;
	logic                       s_axis_tready;
	logic [31:0]                s_axis_tdata = '0;
	logic [0:0]                 s_axis_tuser = '0;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b0;
	logic [31:0]                m_axis_tdata;

	decimate_and_bandpass_audio i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [59:0] hp_ff, lp_ff;
	logic [39:0] hp_fb, lp_fb;
	longint      prev_in [2];
	longint      hp_x [2];
	longint      hp_y [2];
	longint      lp_y [2];
	int          in_pos, out_pos, out_lim;

	audio_beat_t pending_beats [$];
	audio_out_t  expected_outputs [$];
	audio_beat_t beat_on_bus;
	audio_out_t  got_out, want_out;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          beats_queued = 0;
	int          beats_taken = 0;
	int          blocks_started = 0;
	int          outputs_checked = 0;
	int          mismatches = 0;
	int          cycles = 0;

	function automatic longint coef_at(input logic [59:0] bank, input int k);
		logic [COEF_W-1:0] f;
		f = bank[k*COEF_W +: COEF_W];
		return longint'($signed(f));
	endfunction

	function automatic longint clamp_state(input longint v);
		if (v > STATE_HI)
			return STATE_HI;
		if (v < STATE_LO)
			return STATE_LO;
		return v;
	endfunction

	function automatic longint biquad_out(input logic [59:0] ff, input logic [39:0] fb,
		input longint x0, input longint x1, input longint x2, input longint y1, input longint y2);
		longint acc;
		acc = coef_at(ff, 0) * x0 + coef_at(ff, 1) * x1 + coef_at(ff, 2) * x2
			- coef_at({20'd0, fb}, 0) * y1 - coef_at({20'd0, fb}, 1) * y2;
		acc = acc + (64'sd1 <<< (COEF_FRAC - 1));
		return clamp_state(acc >>> COEF_FRAC);
	endfunction

	task automatic advance_decimator(input audio_beat_t b);
		longint     s, sum, cnt, avg, hp, lp, sc;
		int         len, base;
		audio_out_t o;
		s = longint'($signed(b.sample));
		if (b.start) begin
			len = b.len;
			if (len > BLOCK_CAP)
				len = BLOCK_CAP;
			out_lim = (320 * len + 441) / 882;
			if (out_lim > OUT_CAP)
				out_lim = OUT_CAP;
			in_pos = 0;
			out_pos = 0;
			blocks_started++;
		end
		if (out_pos < out_lim) begin
			base = (441 * out_pos) / 160;
			if (base + 1 == in_pos) begin
				if (base == 0) begin
					sum = prev_in[0] + s;
					cnt = 2;
				end else begin
					sum = prev_in[1] + prev_in[0] + s;
					cnt = 3;
				end
				avg = clamp_state((sum * (64'sd1 <<< SIG_FRAC)) / (cnt * 32768));
				hp = biquad_out(hp_ff, hp_fb, avg, hp_x[0], hp_x[1], hp_y[0], hp_y[1]);
				lp = biquad_out(lp_ff, lp_fb, hp, hp_y[0], hp_y[1], lp_y[0], lp_y[1]);
				hp_x[1] = hp_x[0];
				hp_x[0] = avg;
				hp_y[1] = hp_y[0];
				hp_y[0] = hp;
				lp_y[1] = lp_y[0];
				lp_y[0] = lp;
				sc = (lp * 32767) / (64'sd1 <<< SIG_FRAC);
				if (sc > 32767)
					sc = 32767;
				if (sc < -32767)
					sc = -32767;
				o.sample = sc[15:0];
				o.index = out_pos[9:0];
				expected_outputs.push_back(o);
				out_pos++;
			end
		end
		prev_in[1] = prev_in[0];
		prev_in[0] = s;
		if (in_pos < POS_CAP)
			in_pos++;
	endtask

	task automatic flag_error(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// input side: hold a beat until taken, idle between beats at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				advance_decimator(beat_on_bus);
				beats_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					beat_on_bus = pending_beats.pop_front();
					s_axis_tdata <= {3'd0, beat_on_bus.len, beat_on_bus.sample};
					s_axis_tuser <= beat_on_bus.start;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side: random stalls, each beat checked against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_out.sample = m_axis_tdata[15:0];
				got_out.index = m_axis_tdata[25:16];
				if (expected_outputs.size() == 0) begin
					flag_error($sformatf("unexpected output sample %0d index %0d",
						$signed(got_out.sample), got_out.index));
				end else begin
					want_out = expected_outputs.pop_front();
					outputs_checked++;
					if (got_out.sample !== want_out.sample)
						flag_error($sformatf("sample_out %0d, want %0d (index %0d)",
							$signed(got_out.sample), $signed(want_out.sample), want_out.index));
					if (got_out.index !== want_out.index)
						flag_error($sformatf("out_index %0d, want %0d",
							got_out.index, want_out.index));
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d predictions outstanding",
				cycles, expected_outputs.size());
			$display("decimate_and_bandpass_audio regression: fail");
			$finish;
		end
	end

	function automatic void queue_beat(input logic [15:0] sample, input logic start,
		input logic [12:0] len);
		audio_beat_t b;
		b.sample = sample;
		b.start = start;
		b.len = len;
		pending_beats.push_back(b);
		beats_queued++;
	endfunction

	function automatic logic [15:0] random_sample();
		if ($urandom_range(9) == 0)
			return $urandom_range(1) ? 16'h7FFF : 16'h8000;
		return 16'($urandom);
	endfunction

	function automatic logic [59:0] pack_coefs(input int c0, input int c1, input int c2);
		logic [COEF_W-1:0] f0, f1, f2;
		f0 = c0[COEF_W-1:0];
		f1 = c1[COEF_W-1:0];
		f2 = c2[COEF_W-1:0];
		return {f2, f1, f0};
	endfunction

	task automatic write_coef(input logic [1:0] reg_idx, input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= dba_pkg::ADDR_W'({reg_idx, 3'b000});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (reg_idx)
			dba_pkg::REG_HP_FF: hp_ff = value[59:0];
			dba_pkg::REG_HP_FB: hp_fb = value[39:0];
			dba_pkg::REG_LP_FF: lp_ff = value[59:0];
			dba_pkg::REG_LP_FB: lp_fb = value[39:0];
		endcase
	endtask

	task automatic write_filter(input logic [59:0] hpf, input logic [39:0] hpb,
		input logic [59:0] lpf, input logic [39:0] lpb);
		write_coef(dba_pkg::REG_HP_FF, {4'd0, hpf});
		write_coef(dba_pkg::REG_HP_FB, {24'd0, hpb});
		write_coef(dba_pkg::REG_LP_FF, {4'd0, lpf});
		write_coef(dba_pkg::REG_LP_FB, {24'd0, lpb});
	endtask

	// waits until every beat is taken and every output seen, then lets the block settle
	task automatic wait_drained();
		while (beats_taken != beats_queued || expected_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic queue_random_blocks(input int budget);
		int used, kind, len, count;
		used = 0;
		while (used < budget) begin
			kind = $urandom_range(99);
			if (kind < 8) begin
				// stray samples with no block start
				count = $urandom_range(1, 4);
				for (int k = 0; k < count; k++)
					queue_beat(random_sample(), 1'b0, 13'($urandom));
			end else begin
				if (kind < 70)
					len = $urandom_range(3, 64);
				else if (kind < 78)
					len = $urandom_range(0, 2);
				else if (kind < 88)
					len = $urandom_range(65, 300);
				else
					len = $urandom_range(0, 8191);
				kind = $urandom_range(99);
				if (kind < 70)
					count = len;
				else if (kind < 85)
					count = $urandom_range(1, (len > 1) ? len : 1);
				else
					count = len + $urandom_range(1, 8);
				if (count > 300)
					count = 300;
				if (count < 1)
					count = 1;
				queue_beat(random_sample(), 1'b1, len[12:0]);
				for (int k = 1; k < count; k++)
					queue_beat(random_sample(), 1'b0, 13'($urandom));
			end
			used += count;
		end
	endtask

	initial begin
		hp_ff = '0;
		hp_fb = '0;
		lp_ff = '0;
		lp_fb = '0;
		prev_in = '{0, 0};
		hp_x = '{0, 0};
		hp_y = '{0, 0};
		lp_y = '{0, 0};
		in_pos = 0;
		out_pos = 0;
		out_lim = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing may come out before a block start
		queue_beat(16'h7FFF, 1'b0, 13'h1FFF);
		queue_beat(16'h8000, 1'b0, 13'h0000);
		queue_beat(16'h0000, 1'b0, 13'h1000);
		wait_drained();

		// unity pass-through in both stages
		write_filter(pack_coefs(1 << COEF_FRAC, 0, 0), 40'd0,
			pack_coefs(1 << COEF_FRAC, 0, 0), 40'd0);
		// zero-length block
		queue_beat(16'h1234, 1'b1, 13'd0);
		// two-sample block, then a sample past its end
		queue_beat(16'h7FFF, 1'b1, 13'd2);
		queue_beat(16'h7FFF, 1'b0, 13'd0);
		queue_beat(16'h8000, 1'b0, 13'd0);
		// over-long length taken as the block maximum
		queue_beat(16'h8000, 1'b1, 13'h1FFF);
		queue_beat(16'h8000, 1'b0, 13'd0);
		queue_beat(16'h8000, 1'b0, 13'd0);
		queue_beat(16'h7FFF, 1'b0, 13'd0);
		queue_beat(16'h7FFF, 1'b0, 13'd0);
		queue_beat(16'h7FFF, 1'b0, 13'd0);
		queue_beat(16'h0000, 1'b0, 13'd0);
		queue_beat(16'h0001, 1'b0, 13'd0);
		queue_beat(16'hFFFF, 1'b0, 13'd0);
		// longest legal block, restarted early
		queue_beat(16'h4000, 1'b1, 13'd4096);
		queue_beat(16'hC000, 1'b0, 13'd0);
		queue_beat(16'h5555, 1'b0, 13'd0);
		queue_beat(16'hAAAA, 1'b0, 13'd0);
		queue_beat(16'h0100, 1'b1, 13'd3);
		queue_beat(16'hFF00, 1'b0, 13'd0);
		queue_beat(16'h00FF, 1'b0, 13'd0);
		wait_drained();

		for (int ph = 1; ph <= 4; ph++) begin
			case (ph)
				1: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					write_filter(pack_coefs(117965, -235930, 117965),
						40'(pack_coefs(-235930, 106168, 0)),
						pack_coefs(26214, 52429, 26214),
						40'(pack_coefs(-65536, 39322, 0)));
				end
				2: begin
					send_idle_pct = 66;
					recv_stall_pct = 0;
					write_filter(pack_coefs(-524288, -524288, -524288),
						40'(pack_coefs(524287, 524287, 0)),
						pack_coefs(524287, 524287, 524287),
						40'(pack_coefs(-524288, -524288, 0)));
				end
				3: begin
					send_idle_pct = 0;
					recv_stall_pct = 66;
					write_coef(dba_pkg::REG_HP_FF, '1);
					write_coef(dba_pkg::REG_HP_FB, '1);
					write_coef(dba_pkg::REG_LP_FF, '1);
					write_coef(dba_pkg::REG_LP_FB, '1);
				end
				default: begin
					send_idle_pct = 19;
					recv_stall_pct = 19;
					write_coef(dba_pkg::REG_HP_FF, {$urandom, $urandom});
					write_coef(dba_pkg::REG_HP_FB, {$urandom, $urandom});
					write_coef(dba_pkg::REG_LP_FF, {$urandom, $urandom});
					write_coef(dba_pkg::REG_LP_FB, {$urandom, $urandom});
				end
			endcase
			queue_random_blocks(420);
			wait_drained();
		end

		$display("run covered %0d input beats in %0d blocks under four coefficient sets",
			beats_taken, blocks_started);
		$display("%0d decimated outputs checked, %0d mismatches", outputs_checked, mismatches);
		if (mismatches == 0)
			$display("decimate_and_bandpass_audio regression: pass");
		else
			$display("decimate_and_bandpass_audio regression: fail");
		$finish;
	end

endmodule

// File: filelist.f
rtl/dba_pkg.sv
rtl/dba_regs.sv
rtl/dba_ctrl.sv
rtl/dba_dp.sv
rtl/decimate_and_bandpass_audio.sv
rtl/dba_checker.sv
bench/tb_decimate_and_bandpass_audio.sv
